// ----- rtl/core/urcd_pkg.sv -----
// ----------------------------------------------------------------------------
// urcd_pkg
// Shared types, constants and the microcode program of the ultrasonic range
// computer.
// ----------------------------------------------------------------------------
package urcd_pkg;

  localparam int DigitsDefault = 4;

  localparam logic [15:0] RefDistReset  = 16'd1000;
  localparam logic [15:0] ThresholdReset = 16'd500;
  localparam logic [15:0] StepReset     = 16'd20;
  localparam logic [23:0] SpeedReset    = 24'd22282;  // 0.340 mm per tick in Q16
  localparam logic [23:0] SpeedMax      = 24'hFFFFFF;
  localparam logic [15:0] DistMax       = 16'hFFFF;
  localparam logic [7:0]  SegBlank      = 8'hFF;

  // 0xCCCD / 2^19 approximates 1/10 exactly for every 16-bit value.
  localparam logic [16:0] RecipTen      = 17'd52429;
  localparam int          RecipShift    = 19;

  localparam logic [5:0]  DivSteps      = 6'd32;  // loop counter start, 33 passes
  localparam logic [5:0]  DigitLast     = 6'd3;   // loop counter start, 4 digits

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_REF_DIST  = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_STEP      = 2'd2
  } reg_idx_t;

  // Event kinds on the input channel.
  typedef enum logic [1:0] {
    MODE_ECHO = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_CAL  = 2'd3
  } mode_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ADD,
    OP_SUB,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_DIVEND,
    OP_MUL,
    OP_ECHOEND,
    OP_CLR,
    OP_CONVINIT,
    OP_RECIP,
    OP_DIGIT,
    OP_EMIT
  } op_t;

  // Sequencing conditions.
  typedef enum logic [2:0] {
    C_NEXT,      // fall through
    C_ALWAYS,    // jump to target
    C_WAIT_IN,   // hold until a word is accepted, then fall through
    C_MODE,      // jump to target plus event kind
    C_ZERO_TICK, // jump to target when no echo time is stored
    C_LOOP,      // jump to target while the loop counter is not zero
    C_NOT_SEEN,  // jump to target when no echo arrived
    C_OUT_BUSY   // hold while the output slot is taken, then jump to target
  } cond_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  localparam upc_t PcWait    = 4'd0;
  localparam upc_t PcDisp    = 4'd1;
  localparam upc_t PcModes   = 4'd2;
  localparam upc_t PcDivLoop = 4'd6;
  localparam upc_t PcEcho    = 4'd8;
  localparam upc_t PcNoEcho  = 4'd10;
  localparam upc_t PcConv    = 4'd11;
  localparam upc_t PcRecip   = 4'd12;

  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_LOAD,     cond: C_WAIT_IN,   target: PcWait};
      4'd1:    w = '{op: OP_NOP,      cond: C_MODE,      target: PcModes};
      4'd2:    w = '{op: OP_NOP,      cond: C_ALWAYS,    target: PcEcho};
      4'd3:    w = '{op: OP_ADD,      cond: C_ALWAYS,    target: PcConv};
      4'd4:    w = '{op: OP_SUB,      cond: C_ALWAYS,    target: PcConv};
      4'd5:    w = '{op: OP_DIVINIT,  cond: C_ZERO_TICK, target: PcConv};
      4'd6:    w = '{op: OP_DIVSTEP,  cond: C_LOOP,      target: PcDivLoop};
      4'd7:    w = '{op: OP_DIVEND,   cond: C_ALWAYS,    target: PcConv};
      4'd8:    w = '{op: OP_MUL,      cond: C_NOT_SEEN,  target: PcNoEcho};
      4'd9:    w = '{op: OP_ECHOEND,  cond: C_ALWAYS,    target: PcConv};
      4'd10:   w = '{op: OP_CLR,      cond: C_NEXT,      target: PcConv};
      4'd11:   w = '{op: OP_CONVINIT, cond: C_NEXT,      target: PcRecip};
      4'd12:   w = '{op: OP_RECIP,    cond: C_NEXT,      target: PcRecip};
      4'd13:   w = '{op: OP_DIGIT,    cond: C_LOOP,      target: PcRecip};
      4'd14:   w = '{op: OP_EMIT,     cond: C_OUT_BUSY,  target: PcWait};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,    target: PcWait};
    endcase
    return w;
  endfunction

  // Active-low seven-segment codes of the decimal digits.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] s;
    unique case (digit)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/ultrasonic_range_calc_display.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_range_calc_display
// Time-of-flight range computer with alarm and four-digit seven-segment
// output, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Word contents
//   in_*      input      in_valid/in_ready  mode, echo ticks, echo seen flag
//   out_*     output     out_valid/out_ready distance, alarm, four segment codes
//   cfg_*     input      cfg_we only        register index and 16-bit data
//
// A calibrate word runs the one-bit-per-cycle restoring divider; a calibrate
// with no stored echo time skips the divider. Decimal conversion costs two
// microcode steps per digit. in_ready returns with out_valid, so the next
// word is taken no earlier than the cycle in which out_valid rises. Reset
// restores the register defaults and the speed of sound; no memory needs
// clearing. A stalled output holds its word while the next input word is
// already accepted and worked on; the sequencer waits at its last step only
// if that second result is ready before the first has been taken.
// ----------------------------------------------------------------------------
module ultrasonic_range_calc_display #(
  parameter int DIGITS = urcd_pkg::DigitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_echo_ticks,
  input  logic        in_echo_seen,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_distance_mm,
  output logic        out_alarm,
  output logic [7:0]  out_seg_ones,
  output logic [7:0]  out_seg_tens,
  output logic [7:0]  out_seg_hundreds,
  output logic [7:0]  out_seg_thousands,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import urcd_pkg::*;

  // Digit positions at or above this count are shown blank.
  localparam logic [2:0] DigitCount = 3'(DIGITS);

  // Sequencer.
  upc_t   pc_r, pc_nxt;
  uword_t uw;
  logic [5:0] cnt_r, cnt_nxt;

  // Configuration registers.
  logic [15:0] ref_dist_r, threshold_r, step_r;

  // Architectural state.
  logic [23:0] speed_r, speed_nxt;
  logic [15:0] last_ticks_r, last_ticks_nxt;
  logic [15:0] dist_r, dist_nxt;

  // Latched input word.
  mode_t       mode_r;
  logic [15:0] ticks_r;
  logic        seen_r;

  // Working registers.
  logic [38:0] prod_r, prod_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] work_r, work_nxt;
  logic [32:0] qprod_r, qprod_nxt;
  logic [7:0]  seg_r [4];
  logic [7:0]  seg_nxt [4];

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_dist_r;
  logic        out_alarm_r;
  logic [7:0]  out_seg_r [4];

  // Combinational helpers.
  logic        accept;
  logic        out_free;
  logic [16:0] trial;
  logic [16:0] trial_diff;
  logic        trial_ge;
  logic [13:0] quot10;
  logic [15:0] digit_rem;
  logic [1:0]  digit_pos;

  assign uw       = ucode(pc_r);
  assign in_ready = (pc_r == PcWait);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // One restoring-division step: shift in the next numerator bit.
  assign trial      = {rem_r, quo_r[32]};
  assign trial_diff = trial - {1'b0, last_ticks_r};
  assign trial_ge   = (trial >= {1'b0, last_ticks_r});

  // Digit extraction from the registered reciprocal product.
  assign quot10    = qprod_r[RecipShift +: 14];
  assign digit_rem = work_r - ({2'b0, quot10} * 16'd10);
  assign digit_pos = 2'(DigitLast - cnt_r);

  // Next microcode address.
  always_comb begin
    pc_nxt = pc_r + 4'd1;
    unique case (uw.cond)
      C_NEXT:      pc_nxt = pc_r + 4'd1;
      C_ALWAYS:    pc_nxt = uw.target;
      C_WAIT_IN:   pc_nxt = accept ? pc_r + 4'd1 : pc_r;
      C_MODE:      pc_nxt = uw.target + {2'b0, mode_r};
      C_ZERO_TICK: pc_nxt = (last_ticks_r == '0) ? uw.target : pc_r + 4'd1;
      C_LOOP:      pc_nxt = (cnt_r != '0) ? uw.target : pc_r + 4'd1;
      C_NOT_SEEN:  pc_nxt = !seen_r ? uw.target : pc_r + 4'd1;
      C_OUT_BUSY:  pc_nxt = out_free ? uw.target : pc_r;
      default:     pc_nxt = PcWait;
    endcase
  end

  // Datapath, one operation per control word.
  always_comb begin
    cnt_nxt        = cnt_r;
    speed_nxt      = speed_r;
    last_ticks_nxt = last_ticks_r;
    dist_nxt       = dist_r;
    prod_nxt       = prod_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    work_nxt       = work_r;
    qprod_nxt      = qprod_r;
    seg_nxt        = seg_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (uw.op)
      OP_NOP, OP_LOAD: begin
      end
      OP_ADD: dist_nxt = dist_r + step_r;
      OP_SUB: dist_nxt = dist_r - step_r;
      OP_DIVINIT: begin
        rem_nxt = '0;
        quo_nxt = {ref_dist_r, 17'b0};
        cnt_nxt = DivSteps;
      end
      OP_DIVSTEP: begin
        rem_nxt = trial_ge ? trial_diff[15:0] : trial[15:0];
        quo_nxt = {quo_r[31:0], trial_ge};
        cnt_nxt = cnt_r - 6'd1;
      end
      OP_DIVEND: speed_nxt = (|quo_r[32:24]) ? SpeedMax : quo_r[23:0];
      OP_MUL: prod_nxt = {24'b0, ticks_r[15:1]} * {15'b0, speed_r};
      OP_ECHOEND: begin
        last_ticks_nxt = ticks_r;
        dist_nxt       = (|prod_r[38:32]) ? DistMax : prod_r[31:16];
      end
      OP_CLR: dist_nxt = '0;
      OP_CONVINIT: begin
        work_nxt = dist_r;
        cnt_nxt  = DigitLast;
      end
      OP_RECIP: qprod_nxt = {17'b0, work_r} * {16'b0, RecipTen};
      OP_DIGIT: begin
        seg_nxt[digit_pos] = ({1'b0, digit_pos} >= DigitCount) ? SegBlank
                                                                : seg_code(digit_rem[3:0]);
        work_nxt = {2'b0, quot10};
        cnt_nxt  = cnt_r - 6'd1;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PcWait;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      ref_dist_r   <= RefDistReset;
      threshold_r  <= ThresholdReset;
      step_r       <= StepReset;
      speed_r      <= SpeedReset;
      last_ticks_r <= '0;
      dist_r       <= '0;
    end else begin
      pc_r         <= pc_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      speed_r      <= speed_nxt;
      last_ticks_r <= last_ticks_nxt;
      dist_r       <= dist_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REF_DIST:  ref_dist_r  <= cfg_data;
          REG_THRESHOLD: threshold_r <= cfg_data;
          REG_STEP:      step_r      <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    work_r  <= work_nxt;
    qprod_r <= qprod_nxt;
    seg_r   <= seg_nxt;
    if (accept) begin
      mode_r  <= mode_t'(in_mode);
      ticks_r <= in_echo_ticks;
      seen_r  <= in_echo_seen;
    end
    if (uw.op == OP_EMIT && out_free) begin
      out_dist_r  <= dist_r;
      out_alarm_r <= (dist_r < threshold_r);
      out_seg_r   <= seg_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_distance_mm   = out_dist_r;
  assign out_alarm         = out_alarm_r;
  assign out_seg_ones      = out_seg_r[0];
  assign out_seg_tens      = out_seg_r[1];
  assign out_seg_hundreds  = out_seg_r[2];
  assign out_seg_thousands = out_seg_r[3];

endmodule

// ----- rtl/core/urcd_checker.sv -----
// ----------------------------------------------------------------------------
// urcd_checker
// Port-level checks of the ultrasonic range computer, bound to its top level.
// ----------------------------------------------------------------------------
module urcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_distance_mm,
  input logic [7:0]  out_seg_ones
);

  // A result word that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_mm))
    else $error("stalled result word changed");

  // The sequencer works on one input word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The ones digit is always shown and is a decimal digit code.
  a_ones_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seg_ones == 8'hC0 || out_seg_ones == 8'hF9 ||
                   out_seg_ones == 8'hA4 || out_seg_ones == 8'hB0 ||
                   out_seg_ones == 8'h99 || out_seg_ones == 8'h92 ||
                   out_seg_ones == 8'h82 || out_seg_ones == 8'hF8 ||
                   out_seg_ones == 8'h80 || out_seg_ones == 8'h90))
    else $error("ones digit code is not a decimal digit");

endmodule

bind ultrasonic_range_calc_display urcd_checker u_urcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_distance_mm (out_distance_mm),
  .out_seg_ones    (out_seg_ones)
);
